>>> hw/rtl/sdaf_pkg.sv
// ----------------------------------------------------------------------------
// sdaf_pkg
// Shared constants and types for the signed decimal ascii formatter.
// ----------------------------------------------------------------------------
package sdaf_pkg;

    localparam int MAX_DIGITS  = 5;
    localparam int VALUE_W     = 16;
    localparam int COUNT_W     = 3;
    localparam int MAG_W       = VALUE_W + 1;
    localparam int BIT_CNT_W   = $clog2(MAG_W);
    localparam int BCD_W       = 4;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

    // control shared by every cell of the chain
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctrl;

endpackage

>>> hw/rtl/signed_decimal_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_top
// Formats a signed 16-bit value as an optional minus sign and a fixed number
// of decimal digits, one ascii character per output transaction.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       input      i_valid / o_stall   i_value[15:0], i_digit_count[2:0]
//  out      output     o_valid / i_stall   o_character[7:0], o_last
//
//  after a value is accepted, it runs 17 shift steps through the bcd cell row,
//  then one character per cycle while the output is not stalled (up to 6).
//  the input is taken only while idle; the last character may still wait in
//  the output register when the next value is taken.
//  i_rst_n is synchronous; it clears control state, the digit cells need none.
//  a stall on the output holds the character register and pauses emission.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter_top #(
    parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [sdaf_pkg::VALUE_W-1:0] i_value,
    input  logic [sdaf_pkg::COUNT_W-1:0]      i_digit_count,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sdaf_pkg::CHAR_W-1:0]       o_character,
    output logic                              o_last
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]                          r_state, n_state;
    logic [sdaf_pkg::MAG_W-1:0]          r_mag, n_mag;
    logic                                r_neg, n_neg;
    logic [IDX_W-1:0]                    r_idx, n_idx;
    logic [sdaf_pkg::BIT_CNT_W-1:0]      r_cnt, n_cnt;
    logic                                r_out_valid, n_out_valid;
    logic [sdaf_pkg::CHAR_W-1:0]         r_char, n_char;
    logic                                r_last, n_last;

    sdaf_pkg::t_cell_ctrl                w_ctrl;
    logic [sdaf_pkg::BCD_W-1:0]          w_digit [MAX_DIGITS];
    logic                                w_accept;
    logic                                w_load;
    logic                                w_in_neg;
    logic [sdaf_pkg::MAG_W-1:0]          w_in_mag;
    logic [IDX_W-1:0]                    w_start_idx;

    sdaf_chain #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_bit   (r_mag[sdaf_pkg::MAG_W-1]),
        .o_digit (w_digit)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    // output register is free or being emptied this cycle
    assign w_load   = !r_out_valid || !i_stall;

    assign w_in_neg = i_value[sdaf_pkg::VALUE_W-1];
    // 17-bit magnitude so the most negative value negates cleanly
    assign w_in_mag = w_in_neg
                    ? (sdaf_pkg::MAG_W'(0) - {i_value[sdaf_pkg::VALUE_W-1], i_value})
                    : {1'b0, i_value};

    always_comb begin
        if (i_digit_count == '0) begin
            w_start_idx = '0;
        end else if (32'(i_digit_count) > MAX_DIGITS) begin
            w_start_idx = IDX_W'(MAX_DIGITS - 1);
        end else begin
            w_start_idx = IDX_W'(i_digit_count - 3'd1);
        end
    end

    assign w_ctrl.clear = w_accept;
    assign w_ctrl.shift = (r_state == ST_CONV);

    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_char      = r_char;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_mag   = w_in_mag;
                    n_neg   = w_in_neg;
                    n_idx   = w_start_idx;
                    n_cnt   = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_mag = r_mag << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == sdaf_pkg::BIT_CNT_W'(sdaf_pkg::MAG_W - 1)) begin
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_char      = sdaf_pkg::ASCII_MINUS;
                    n_last      = 1'b0;
                    n_state     = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_char      = sdaf_pkg::ASCII_ZERO | {4'd0, w_digit[r_idx]};
                    n_last      = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

>>> hw/rtl/sdaf_cell.sv
// ----------------------------------------------------------------------------
// sdaf_cell
// One bcd digit of the shift-and-add-3 chain; takes a bit from the lower
// neighbor and hands its top bit to the upper neighbor on each shift.
// ----------------------------------------------------------------------------
module sdaf_cell (
    input  logic                           i_clk,
    input  sdaf_pkg::t_cell_ctrl           i_ctrl,
    input  logic                           i_bit,
    output logic                           o_carry,
    output logic [sdaf_pkg::BCD_W-1:0]     o_digit
);

    logic [sdaf_pkg::BCD_W-1:0] r_digit;
    logic [sdaf_pkg::BCD_W-1:0] n_digit;
    logic [sdaf_pkg::BCD_W-1:0] w_adj;

    // digits of 5 and up get +3 so the doubling carries in decimal
    assign w_adj   = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_carry = w_adj[sdaf_pkg::BCD_W-1];
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[sdaf_pkg::BCD_W-2:0], i_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

>>> hw/rtl/sdaf_chain.sv
// ----------------------------------------------------------------------------
// sdaf_chain
// Row of bcd cells; the lowest takes the magnitude msb first, the carry out of
// the top cell is dropped so the row holds the low digits only.
// ----------------------------------------------------------------------------
module sdaf_chain #(
    parameter int MAX_DIGITS = sdaf_pkg::MAX_DIGITS
) (
    input  logic                           i_clk,
    input  sdaf_pkg::t_cell_ctrl           i_ctrl,
    input  logic                           i_bit,
    output logic [sdaf_pkg::BCD_W-1:0]     o_digit [MAX_DIGITS]
);

    logic [MAX_DIGITS:0] w_link;

    assign w_link[0] = i_bit;

    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        sdaf_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_bit   (w_link[g]),
            .o_carry (w_link[g+1]),
            .o_digit (o_digit[g])
        );
    end

    // top carry is the part above 10^MAX_DIGITS, discarded on purpose
    logic w_unused_top;
    assign w_unused_top = w_link[MAX_DIGITS];

endmodule

>>> bench/signed_decimal_ascii_formatter_checker.sv
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_checker
// Watches both channels of the formatter, predicts the characters of every
// accepted value and compares each output transaction with the oldest one.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [sdaf_pkg::VALUE_W-1:0] i_value,
    input  logic [sdaf_pkg::COUNT_W-1:0]        i_digit_count,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [sdaf_pkg::CHAR_W-1:0]         i_character,
    input  logic                                i_last,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int RADIX = 10;

    typedef struct packed {
        logic [sdaf_pkg::CHAR_W-1:0] character;
        logic                        last;
    } t_ascii_char;

    t_ascii_char pending_chars[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_chars.size();

    // queue the sign and the low digits of the magnitude, most significant first
    function automatic void queue_decimal_chars(
        input logic signed [sdaf_pkg::VALUE_W-1:0] value,
        input logic [sdaf_pkg::COUNT_W-1:0]        digit_count
    );
        logic                        negative;
        logic [sdaf_pkg::MAG_W-1:0]  magnitude;
        int                          num_digits;
        logic [sdaf_pkg::CHAR_W-1:0] digits[sdaf_pkg::MAX_DIGITS];
        t_ascii_char                 entry;

        negative   = value[sdaf_pkg::VALUE_W-1];
        magnitude  = {1'b0, value};
        if (negative) begin
            magnitude = sdaf_pkg::MAG_W'((1 << sdaf_pkg::VALUE_W) - magnitude);
        end
        num_digits = int'(digit_count);
        if (num_digits < 1) begin
            num_digits = 1;
        end
        if (num_digits > sdaf_pkg::MAX_DIGITS) begin
            num_digits = sdaf_pkg::MAX_DIGITS;
        end
        for (int i = 0; i < num_digits; i++) begin
            digits[i] = sdaf_pkg::CHAR_W'(sdaf_pkg::ASCII_ZERO + (magnitude % RADIX));
            magnitude = sdaf_pkg::MAG_W'(magnitude / RADIX);
        end
        if (negative) begin
            entry.character = sdaf_pkg::ASCII_MINUS;
            entry.last      = 1'b0;
            pending_chars.push_back(entry);
        end
        for (int i = num_digits - 1; i >= 0; i--) begin
            entry.character = digits[i];
            entry.last      = (i == 0);
            pending_chars.push_back(entry);
        end
    endfunction

    initial begin
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_ascii_char want;
        if (i_rst_n) begin
            // retire outputs before queueing new values of the same edge
            if (i_out_valid && !i_out_stall) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected transaction: character %0d last %0b",
                           i_character, i_last);
                    fail_count++;
                end else begin
                    want = pending_chars.pop_front();
                    if (i_character !== want.character) begin
                        $error("character: expected %0d, got %0d",
                               want.character, i_character);
                        fail_count++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                queue_decimal_chars(i_value, i_digit_count);
            end
        end
    end

endmodule

>>> bench/signed_decimal_ascii_formatter_top_tb.sv
// ----------------------------------------------------------------------------
// signed_decimal_ascii_formatter_top_tb
// Drives directed and random values with random idle and stall patterns into
// the formatter; the checker beside it predicts and compares the characters.
// ----------------------------------------------------------------------------
module signed_decimal_ascii_formatter_top_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 130;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_stall;
    logic signed [sdaf_pkg::VALUE_W-1:0] i_value;
    logic [sdaf_pkg::COUNT_W-1:0]        i_digit_count;
    logic                                o_valid;
    logic                                i_stall;
    logic [sdaf_pkg::CHAR_W-1:0]         o_character;
    logic                                o_last;

    int fail_count;
    int chars_pending;
    int cycle_count;
    int sender_idle_pct;
    int receiver_stall_pct;

    signed_decimal_ascii_formatter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_value       (i_value),
        .i_digit_count (i_digit_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_character   (o_character),
        .o_last        (o_last)
    );

    signed_decimal_ascii_formatter_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_value       (i_value),
        .i_digit_count (i_digit_count),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_character   (o_character),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (chars_pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall     <= ($urandom_range(0, 99) < receiver_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_decimal_ascii_formatter_top: mismatch");
            $finish;
        end
    end

    // one transaction on the input channel, after a random idle gap
    task automatic send_value(input logic signed [sdaf_pkg::VALUE_W-1:0] value,
                              input logic [sdaf_pkg::COUNT_W-1:0] digit_count);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_value       <= value;
        i_digit_count <= digit_count;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        logic signed [sdaf_pkg::VALUE_W-1:0] value;
        logic [sdaf_pkg::COUNT_W-1:0]        digit_count;

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_value            = '0;
        i_digit_count      = '0;
        i_stall            = 1'b0;
        cycle_count        = 0;
        sender_idle_pct    = 30;
        receiver_stall_pct = 60;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, zero and saturated counts, truncated negatives
        send_value(16'sd32767, 3'd5);
        send_value(-16'sd32768, 3'd5);
        send_value(16'sd0, 3'd5);
        send_value(-16'sd1, 3'd1);
        send_value(16'sd1, 3'd1);
        send_value(-16'sd32768, 3'd2);
        send_value(16'sd32767, 3'd3);
        send_value(16'sd0, 3'd0);
        send_value(16'sd123, 3'd7);
        send_value(-16'sd456, 3'd6);
        send_value(-16'sd32768, 3'd0);
        send_value(16'sd12345, 3'd4);
        send_value(-16'sd12345, 3'd5);
        send_value(16'sd9, 3'd2);
        send_value(-16'sd10, 3'd1);
        send_value(16'sd32767, 3'd1);
        send_value(-16'sd32767, 3'd5);
        send_value(16'sd100, 3'd3);
        send_value(-16'sd100, 3'd2);
        send_value(16'sd0, 3'd1);
        send_value(-16'sd5, 3'd7);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 3) begin
                sender_idle_pct    = 60;
                receiver_stall_pct = 30;
            end else if (k == 2 * RANDOM_ITEMS / 3) begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            case ($urandom_range(0, 3))
                0:       value = sdaf_pkg::VALUE_W'($urandom_range(0, 199) - 100);
                1:       value = sdaf_pkg::VALUE_W'((16'sd1 <<< $urandom_range(0, 15))
                                                    - $urandom_range(0, 1));
                default: value = sdaf_pkg::VALUE_W'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0) begin
                digit_count = sdaf_pkg::COUNT_W'($urandom_range(0, 7));
            end else begin
                digit_count = sdaf_pkg::COUNT_W'($urandom_range(1, sdaf_pkg::MAX_DIGITS));
            end
            send_value(value, digit_count);
        end
        i_valid <= 1'b0;

        while (chars_pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && chars_pending == 0) begin
            $display("signed_decimal_ascii_formatter_top: match");
        end else begin
            $display("signed_decimal_ascii_formatter_top: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/sdaf_pkg.sv
hw/rtl/sdaf_cell.sv
hw/rtl/sdaf_chain.sv
hw/rtl/signed_decimal_ascii_formatter_top.sv
bench/signed_decimal_ascii_formatter_checker.sv
bench/signed_decimal_ascii_formatter_top_tb.sv
